// ===== src/json_string_escape_utf8_encoder_core_macros.svh =====
// Assertion macros shared by the RTL of the JSON escape / UTF-8 encoder.
// Define ASSERT_OFF to drop every check from the build.
`ifndef JSON_STRING_ESCAPE_UTF8_ENCODER_CORE_MACROS_SVH
`define JSON_STRING_ESCAPE_UTF8_ENCODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check gated by the active-low reset.
`define JSEU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that must hold at every edge, reset included.
`define JSEU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define JSEU_ASSERT(label, clk, rst_n, prop, msg)

`define JSEU_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== src/jseu_pkg.sv =====
`default_nettype none

package jseu_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Range boundaries of the UTF-8 forms
  localparam logic [CP_W-1:0] CP_MAX_1B = 21'h00007F;
  localparam logic [CP_W-1:0] CP_MAX_2B = 21'h0007FF;
  localparam logic [CP_W-1:0] CP_MAX_3B = 21'h00FFFF;
  localparam logic [CP_W-1:0] CP_MAX_4B = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;

  // Lead and continuation markers
  localparam logic [BYTE_W-1:0] LEAD_2B   = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3B   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4B   = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;
  localparam logic [BYTE_W-1:0] BACKSLASH = 8'h5C;

  // Error codes on the result channel
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_SURROGATE = 2'd1;
  localparam logic [1:0] ERR_RANGE     = 2'd2;

  // One classified code point: up to four bytes, first byte at index 0
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;
    logic [1:0]             last_idx;
    logic [1:0]             err;
  } desc_t;

  // Escape letter for characters JSON escapes, zero otherwise
  function automatic logic [BYTE_W-1:0] escape_letter(input logic [CP_W-1:0] cp);
    logic [BYTE_W-1:0] letter;
    case (cp)
      21'h000022: letter = 8'h22;  // quote
      21'h00005C: letter = 8'h5C;  // backslash
      21'h00002F: letter = 8'h2F;  // slash
      21'h000008: letter = 8'h62;  // b
      21'h00000C: letter = 8'h66;  // f
      21'h00000A: letter = 8'h6E;  // n
      21'h00000D: letter = 8'h72;  // r
      21'h000009: letter = 8'h74;  // t
      default:    letter = 8'h00;
    endcase
    return letter;
  endfunction

endpackage

`default_nettype wire

// ===== src/json_string_escape_utf8_encoder_core.sv =====
// JSON string escaper and UTF-8 encoder.
// Input channel (in_valid_i / in_ready_o / code_point_i): one code point per
// request. Output channel (out_valid_o / out_ready_i): one byte per request,
// with last_byte_o on the final byte of a code point and error_code_o.
// Escaped characters give a backslash and a letter; other code points give
// their 1 to 4 UTF-8 bytes; a surrogate or a value above 0x10FFFF gives one
// byte of zero with last_byte_o set and an error code.
// The first byte of a request is written into the queue and then into the
// output register before it is valid. Throughput: one byte per cycle while
// the queue holds bytes and the receiver is ready; the 1 to 4 bytes of a
// code point are serialised by the single output register.
// A classify stage feeds a QueueDepth-entry queue; the input keeps taking
// requests while the queue has room, so a stalled receiver stops the input
// only once the queue is full. Stalled output holds its byte unchanged.
// Reset empties the queue and clears the output valid; no clearing pass.
`default_nettype none

module json_string_escape_utf8_encoder_core #(
  parameter int unsigned QueueDepth = jseu_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [jseu_pkg::CP_W-1:0]   code_point_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [jseu_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                             last_byte_o,
  output logic [1:0]                       error_code_o
);
  import jseu_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  logic  empty;
  desc_t desc;
  desc_t head;

  jseu_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_point_i (code_point_i),
    .full_i       (full),
    .push_o       (push),
    .desc_o       (desc)
  );

  jseu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  jseu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_byte_o  (last_byte_o),
    .error_code_o (error_code_o)
  );

endmodule

`default_nettype wire

// ===== src/jseu_front.sv =====
`default_nettype none

module jseu_front (
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [jseu_pkg::CP_W-1:0]   code_point_i,
  input  wire logic                        full_i,
  output logic                             push_o,
  output jseu_pkg::desc_t                  desc_o
);
  import jseu_pkg::*;

  logic [BYTE_W-1:0] esc;

  // Take a request whenever the queue has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Classify the code point and build its byte sequence
  always_comb begin
    esc    = escape_letter(code_point_i);
    desc_o = '0;
    if (esc != '0) begin
      desc_o.bytes[0] = BACKSLASH;
      desc_o.bytes[1] = esc;
      desc_o.last_idx = 2'd1;
    end else if (code_point_i <= CP_MAX_1B) begin
      desc_o.bytes[0] = code_point_i[7:0];
      desc_o.last_idx = 2'd0;
    end else if (code_point_i <= CP_MAX_2B) begin
      desc_o.bytes[0] = LEAD_2B | {3'b000, code_point_i[10:6]};
      desc_o.bytes[1] = CONT_MARK | {2'b00, code_point_i[5:0]};
      desc_o.last_idx = 2'd1;
    end else if (code_point_i >= SURR_LO && code_point_i <= SURR_HI) begin
      desc_o.err      = ERR_SURROGATE;
      desc_o.last_idx = 2'd0;
    end else if (code_point_i <= CP_MAX_3B) begin
      desc_o.bytes[0] = LEAD_3B | {4'b0000, code_point_i[15:12]};
      desc_o.bytes[1] = CONT_MARK | {2'b00, code_point_i[11:6]};
      desc_o.bytes[2] = CONT_MARK | {2'b00, code_point_i[5:0]};
      desc_o.last_idx = 2'd2;
    end else if (code_point_i <= CP_MAX_4B) begin
      desc_o.bytes[0] = LEAD_4B | {5'b00000, code_point_i[20:18]};
      desc_o.bytes[1] = CONT_MARK | {2'b00, code_point_i[17:12]};
      desc_o.bytes[2] = CONT_MARK | {2'b00, code_point_i[11:6]};
      desc_o.bytes[3] = CONT_MARK | {2'b00, code_point_i[5:0]};
      desc_o.last_idx = 2'd3;
    end else begin
      desc_o.err      = ERR_RANGE;
      desc_o.last_idx = 2'd0;
    end
  end

endmodule

`default_nettype wire

// ===== src/jseu_queue.sv =====
`default_nettype none
`include "json_string_escape_utf8_encoder_core_macros.svh"

module jseu_queue #(
  parameter int unsigned Depth = jseu_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire jseu_pkg::desc_t  desc_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output jseu_pkg::desc_t       head_o,
  output logic                  empty_o
);
  import jseu_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer wrap and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  `JSEU_ASSERT(a_no_overflow, clk_i, rst_ni, push_i |-> !full_o, "push into full queue")
  `JSEU_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i |-> !empty_o, "pop from empty queue")
  `JSEU_ASSERT_ALWAYS(a_cnt_range, clk_i, !rst_ni || cnt_q <= CntW'(Depth), "queue count out of range")

endmodule

`default_nettype wire

// ===== src/jseu_back.sv =====
`default_nettype none
`include "json_string_escape_utf8_encoder_core_macros.svh"

module jseu_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire jseu_pkg::desc_t               head_i,
  input  wire logic                          empty_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [jseu_pkg::BYTE_W-1:0]        out_byte_o,
  output logic                               last_byte_o,
  output logic [1:0]                         error_code_o
);
  import jseu_pkg::*;

  logic              out_valid_q;
  logic [1:0]        idx_q;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;
  logic [1:0]        err_q;
  logic              load;
  logic              is_last;

  // Output register takes the next byte when empty or being drained
  assign load    = !empty_i && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Byte payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      last_q <= is_last;
      err_q  <= head_i.err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign last_byte_o  = last_q;
  assign error_code_o = err_q;

  `JSEU_ASSERT(a_err_single, clk_i, rst_ni,
    out_valid_q && err_q != ERR_NONE |-> byte_q == '0 && last_q, "bad error result")
  `JSEU_ASSERT(a_partial_held, clk_i, rst_ni,
    idx_q != 2'd0 |-> !empty_i && idx_q <= head_i.last_idx, "partial item lost")

endmodule

`default_nettype wire
